// File: sv/log2_latency_histogram_assert.svh
// Assertion macros for the log2 latency histogram.
// Included by the top-level module, which carries the concurrent assertions; needs no package.
`ifndef LOG2_LATENCY_HISTOGRAM_ASSERT_SVH
`define LOG2_LATENCY_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define LLH_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("log2_latency_histogram: assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define LLH_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("log2_latency_histogram: assertion failed");

`endif

// File: sv/llh_pkg.sv
// Shared types and constants of the log2 latency histogram.
// No dependencies; imported by every module of the block.
package llh_pkg;

    localparam int VAL_W  = 64;
    localparam int CNT_W  = 48;
    localparam int P_W    = 14;
    // Product of a percentile and the sample count.
    localparam int NEED_W = P_W + CNT_W;
    // Sum of up to 64 saturated bucket counts.
    localparam int CUM_W  = CNT_W + 6;
    // A cumulative count at or above 2^BIG_BIT beats any possible need.
    localparam int BIG_BIT = 50;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [P_W-1:0]   SCALE   = 14'd10000;

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [VAL_W-1:0] sample_value;
        logic [P_W-1:0]   percentile_hundredths;
    } t_item;

    typedef struct packed {
        logic [VAL_W-1:0] percentile_value;
        logic [CNT_W-1:0] sample_count;
        logic [VAL_W-1:0] sample_sum;
        logic [VAL_W-1:0] smallest_sample;
        logic [VAL_W-1:0] largest_sample;
    } t_result;

endpackage

// File: sv/llh_bucket_index.sv
// Two-stage leading-one finder that maps a sample to its log2 bucket.
// Depends on llh_pkg for the sample width.
module llh_bucket_index
    import llh_pkg::*;
#(
    parameter int BUCKETS = 64,
    parameter int BW      = 6
) (
    input  logic             i_clk,
    input  logic [VAL_W-1:0] i_value,
    output logic [BW-1:0]    o_bucket
);

    function automatic logic [2:0] msb_of_byte(input logic [7:0] b);
        logic [2:0] pos;
        pos = 3'd0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                pos = 3'(k);
            end
        end
        return pos;
    endfunction

    logic [7:0] r_nz;
    logic [2:0] r_msb [8];
    logic [5:0] pos;
    logic [BW-1:0] n_bucket;

    // Stage one: one small encoder per byte.
    always_ff @(posedge i_clk) begin
        for (int g = 0; g < 8; g++) begin
            r_nz[g]  <= |i_value[8*g +: 8];
            r_msb[g] <= msb_of_byte(i_value[8*g +: 8]);
        end
    end

    // Stage two: pick the highest nonzero byte, then clamp to the last bucket.
    always_comb begin
        pos = 6'd0;
        for (int g = 0; g < 8; g++) begin
            if (r_nz[g]) begin
                pos = {3'(g), r_msb[g]};
            end
        end
        if (pos > 6'(BUCKETS - 1)) begin
            n_bucket = BW'(BUCKETS - 1);
        end else begin
            n_bucket = BW'(pos);
        end
    end

    always_ff @(posedge i_clk) begin
        o_bucket <= n_bucket;
    end

endmodule

// File: sv/llh_count_ram.sv
// Bucket count memory: one write port, one registered read port, per-entry valid bits.
// Depends on llh_pkg for the count width.
module llh_count_ram
    import llh_pkg::*;
#(
    parameter int BUCKETS = 64,
    parameter int BW      = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [BW-1:0]    i_rd_addr,
    output logic [CNT_W-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [BW-1:0]    i_wr_addr,
    input  logic [CNT_W-1:0] i_wr_data
);

    logic [CNT_W-1:0]   mem [BUCKETS];
    logic [BUCKETS-1:0] r_valid;
    logic [CNT_W-1:0]   r_rd_data;
    logic               r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    // An entry never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// File: sv/log2_latency_histogram.sv
// Top level of the log2 latency histogram: control sequencer and running statistics.
// Depends on llh_pkg, llh_bucket_index, llh_count_ram and the assertion macro header.
//
// Channel   Direction  Handshake                       Payload
// item      in         start high, busy low at edge    i_item   (t_item)
// result    out        o_result_strobe, one cycle      o_result (t_result)
//
// A record beat passes through the bucket index pipeline (IDX0, IDX1), one memory read (RD)
// and one read-modify-write (WR) before the next beat can be accepted.
// A query beat on an empty histogram ends in NEED; otherwise it walks the buckets from
// zero up to the bucket k that answers (BUCKETS-1 when none does); each bucket of the
// walk costs a memory read, an accumulate, a scale multiply and a compare.
// The result strobe comes in the cycle where busy falls, so a new beat may be taken
// in that same cycle. The receiver cannot stall; results are never held.
// Synchronous reset clears the state, the strobe and the running statistics, and the
// bucket memory through its valid bits, so no clearing pass follows reset.
`include "log2_latency_histogram_assert.svh"

module log2_latency_histogram
    import llh_pkg::*;
#(
    parameter int BUCKETS = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_result_strobe,
    output t_result o_result
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    // Sequencer states. Record beats run IDX0, IDX1, RD, WR; query beats run NEED and then,
    // unless the histogram is empty, loop over Q_RD, Q_ACC, Q_MUL, Q_CMP once per bucket.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_IDX0  = 4'd1;
    localparam logic [3:0] S_IDX1  = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_WR    = 4'd4;
    localparam logic [3:0] S_NEED  = 4'd5;
    localparam logic [3:0] S_Q_RD  = 4'd6;
    localparam logic [3:0] S_Q_ACC = 4'd7;
    localparam logic [3:0] S_Q_MUL = 4'd8;
    localparam logic [3:0] S_Q_CMP = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_strobe, n_strobe;

    // The accepted beat is held for the whole of its work.
    t_item r_item, n_item;

    // Running statistics; they also drive the result ports directly.
    logic [CNT_W-1:0] r_total, n_total;
    logic [VAL_W-1:0] r_sum, n_sum;
    logic [VAL_W-1:0] r_min, n_min;
    logic [VAL_W-1:0] r_max, n_max;
    logic [VAL_W-1:0] r_answer, n_answer;

    // Query walk state.
    logic [BW-1:0]     r_idx, n_idx;
    logic [CUM_W-1:0]  r_cum, n_cum;
    logic [NEED_W-1:0] r_need, n_need;
    logic [VAL_W-1:0]  r_prod, n_prod;
    logic              r_big, n_big;

    logic [BW-1:0]    bucket;
    logic [BW-1:0]    rd_addr;
    logic [CNT_W-1:0] rd_data;
    logic             wr_en;
    logic [CNT_W-1:0] wr_data;
    logic [VAL_W-1:0] upper_edge;
    logic             accept;

    llh_bucket_index #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_index (
        .i_clk    (i_clk),
        .i_value  (r_item.sample_value),
        .o_bucket (bucket)
    );

    llh_count_ram #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (bucket),
        .i_wr_data (wr_data)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // The memory is read every cycle; only the reads in RD and Q_RD are used.
    // Beats never overlap, so a write and a read of the same entry never collide.
    assign rd_addr = (r_state == S_RD) ? bucket : r_idx;
    assign wr_en   = (r_state == S_WR);
    assign wr_data = (rd_data == CNT_MAX) ? rd_data : rd_data + CNT_W'(1);

    // Upper edge 2^(i+1)-1 of bucket i; the last possible bucket gives all ones.
    assign upper_edge = {VAL_W{1'b1}} >> (6'd63 - 6'(r_idx));

    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        n_item   = r_item;
        n_total  = r_total;
        n_sum    = r_sum;
        n_min    = r_min;
        n_max    = r_max;
        n_answer = r_answer;
        n_idx    = r_idx;
        n_cum    = r_cum;
        n_need   = r_need;
        n_prod   = r_prod;
        n_big    = r_big;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_item  = i_item;
                    n_state = (i_item.mode == MODE_RECORD) ? S_IDX0 : S_NEED;
                end
            end
            S_IDX0: begin
                n_state = S_IDX1;
            end
            S_IDX1: begin
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                // The bucket itself is written back through the memory port here.
                n_total  = (r_total == CNT_MAX) ? r_total : r_total + CNT_W'(1);
                n_sum    = r_sum + r_item.sample_value;
                if (r_item.sample_value < r_min) begin
                    n_min = r_item.sample_value;
                end
                if (r_item.sample_value > r_max) begin
                    n_max = r_item.sample_value;
                end
                n_answer = '0;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            S_NEED: begin
                if (r_total == '0) begin
                    n_answer = '0;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_need  = NEED_W'(r_item.percentile_hundredths) * NEED_W'(r_total);
                    n_idx   = '0;
                    n_cum   = '0;
                    n_state = S_Q_RD;
                end
            end
            S_Q_RD: begin
                n_state = S_Q_ACC;
            end
            S_Q_ACC: begin
                n_cum   = r_cum + CUM_W'(rd_data);
                n_state = S_Q_MUL;
            end
            S_Q_MUL: begin
                // Below 2^BIG_BIT the scaled sum fits in 64 bits; above it, it wins anyway.
                n_prod  = VAL_W'(r_cum[BIG_BIT-1:0]) * VAL_W'(SCALE);
                n_big   = |r_cum[CUM_W-1:BIG_BIT];
                n_state = S_Q_CMP;
            end
            S_Q_CMP: begin
                if (r_big || (r_prod >= VAL_W'(r_need))) begin
                    n_answer = upper_edge;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_idx == BW'(BUCKETS - 1)) begin
                    // No bucket reached the requested share: answer with the maximum.
                    n_answer = r_max;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_idx   = r_idx + BW'(1);
                    n_state = S_Q_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_total  <= '0;
            r_sum    <= '0;
            r_min    <= '1;
            r_max    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_total  <= n_total;
            r_sum    <= n_sum;
            r_min    <= n_min;
            r_max    <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_answer <= n_answer;
        r_idx    <= n_idx;
        r_cum    <= n_cum;
        r_need   <= n_need;
        r_prod   <= n_prod;
        r_big    <= n_big;
    end

    // Statistics hold still until the next beat is accepted, so they can feed the
    // result ports without a copy.
    assign o_result_strobe           = r_strobe;
    assign o_result.percentile_value = r_answer;
    assign o_result.sample_count     = r_total;
    assign o_result.sample_sum       = r_sum;
    assign o_result.smallest_sample  = r_min;
    assign o_result.largest_sample   = r_max;

    `LLH_ASSERT_NEXT(a_accept_goes_busy, i_clk, i_rst_n, accept, busy)
    `LLH_ASSERT_IMPL(a_strobe_when_idle, i_clk, i_rst_n, o_result_strobe, !busy)
    `LLH_ASSERT_IMPL(a_strobe_from_end_state, i_clk, i_rst_n, o_result_strobe,
        $past(r_state) == S_WR || $past(r_state) == S_NEED || $past(r_state) == S_Q_CMP)
    `LLH_ASSERT_IMPL(a_record_answers_zero, i_clk, i_rst_n,
        o_result_strobe && (r_item.mode == MODE_RECORD), o_result.percentile_value == '0)

endmodule
